@@ src/assert_macros.svh @@
// Assertion helpers for the RTL files, included by tls_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, masked while reset is held
`define TLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define TLS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/tls_pkg.sv @@
package tls_pkg;

  // Counter and field widths
  localparam int COUNT_BITS = 24;
  localparam int TIME_W     = 24;
  localparam int CMP_W      = (COUNT_BITS > TIME_W) ? COUNT_BITS : TIME_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [COUNT_BITS-1:0] TICK_MAX = '1;

  // Reset durations in ticks
  localparam logic [TIME_W-1:0] RST_RED_TIME    = TIME_W'(30000);
  localparam logic [TIME_W-1:0] RST_YELLOW_TIME = TIME_W'(3000);
  localparam logic [TIME_W-1:0] RST_GREEN_TIME  = TIME_W'(25000);
  localparam logic [TIME_W-1:0] RST_RY_TIME     = TIME_W'(2000);

  // Register indexes on the config port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RED_TIME    = 3'd0,
    REG_YELLOW_TIME = 3'd1,
    REG_GREEN_TIME  = 3'd2,
    REG_RY_TIME     = 3'd3,
    REG_STYLE       = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    STYLE_US = 1'b0,
    STYLE_EU = 1'b1
  } style_t;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_CMD  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_STOP    = 3'd1,
    CMD_RED     = 3'd2,
    CMD_YELLOW  = 3'd3,
    CMD_GREEN   = 3'd4,
    CMD_RY      = 3'd5,
    CMD_ALL_OFF = 3'd6
  } cmd_t;

  // Lamp phase, one-hot
  typedef enum logic [4:0] {
    PH_OFF    = 5'b00001,
    PH_RED    = 5'b00010,
    PH_RY     = 5'b00100,
    PH_GREEN  = 5'b01000,
    PH_YELLOW = 5'b10000
  } phase_t;

  // Phase codes as reported on the result word
  localparam logic [2:0] LP_OFF    = 3'd0;
  localparam logic [2:0] LP_RED    = 3'd1;
  localparam logic [2:0] LP_RY     = 3'd2;
  localparam logic [2:0] LP_GREEN  = 3'd3;
  localparam logic [2:0] LP_YELLOW = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0] red_time;
    logic [TIME_W-1:0] yellow_time;
    logic [TIME_W-1:0] green_time;
    logic [TIME_W-1:0] ry_time;
    style_t            style;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    cmd_t  command;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_in_phase;
    logic              cycling;
    logic [2:0]        light_phase;
    logic              green_lamp;
    logic              yellow_lamp;
    logic              red_lamp;
  } result_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_RED:    code = LP_RED;
      PH_RY:     code = LP_RY;
      PH_GREEN:  code = LP_GREEN;
      PH_YELLOW: code = LP_YELLOW;
      default:   code = LP_OFF;
    endcase
    return code;
  endfunction

endpackage

@@ src/tls_cfg_regs.sv @@
module tls_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tls_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tls_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tls_pkg::cfg_t                  cfg
);
  import tls_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_RED_TIME:    cfg_nxt.red_time    = cfg_wdata[TIME_W-1:0];
        REG_YELLOW_TIME: cfg_nxt.yellow_time = cfg_wdata[TIME_W-1:0];
        REG_GREEN_TIME:  cfg_nxt.green_time  = cfg_wdata[TIME_W-1:0];
        REG_RY_TIME:     cfg_nxt.ry_time     = cfg_wdata[TIME_W-1:0];
        REG_STYLE:       cfg_nxt.style       = style_t'(cfg_wdata[0]);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_time    <= RST_RED_TIME;
      cfg_r.yellow_time <= RST_YELLOW_TIME;
      cfg_r.green_time  <= RST_GREEN_TIME;
      cfg_r.ry_time     <= RST_RY_TIME;
      cfg_r.style       <= STYLE_US;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/tls_in_reg.sv @@
module tls_in_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tls_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic                          take,
  output logic                          item_vld,
  output tls_pkg::item_t                item
);
  import tls_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r;

  // Stage is free when empty or when its word moves on this cycle
  assign in_tready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_tready) vld_nxt = in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_nxt;
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.mode    <= mode_t'(in_tuser);
      item_r.command <= cmd_t'(in_tdata[2:0]);
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

@@ src/tls_core.sv @@
module tls_core (
  input  logic             clk,
  input  logic             rst_n,
  input  tls_pkg::cfg_t    cfg,
  input  logic             item_vld,
  input  tls_pkg::item_t   item,
  output logic             take,
  output logic             out_valid,
  input  logic             out_ready,
  output tls_pkg::result_t result
);
  import tls_pkg::*;

  `include "assert_macros.svh"

  phase_t                phase_r, phase_nxt;
  logic                  cycling_r, cycling_nxt;
  logic [COUNT_BITS-1:0] ticks_r, ticks_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               result_r;

  logic [COUNT_BITS-1:0] ticks_inc;
  logic [TIME_W-1:0]     limit;
  logic                  timed;
  logic                  expired;
  logic [CMP_W-1:0]      ticks_nxt_ext;
  phase_t                phase_adv;

  // Word moves from input stage into result register
  assign take = item_vld && (!out_valid_r || out_ready);

  // Saturating tick count
  assign ticks_inc = (ticks_r == TICK_MAX) ? ticks_r : ticks_r + 1'b1;

  // Duration of the current phase
  always_comb begin
    limit = '0;
    timed = 1'b1;
    unique case (phase_r)
      PH_RED:    limit = cfg.red_time;
      PH_RY:     limit = cfg.ry_time;
      PH_GREEN:  limit = cfg.green_time;
      PH_YELLOW: limit = cfg.yellow_time;
      default:   timed = 1'b0;
    endcase
  end

  assign expired = timed && (CMP_W'(ticks_inc) >= CMP_W'(limit));

  // Successor phase while cycling
  always_comb begin
    unique case (phase_r)
      PH_RED:   phase_adv = (cfg.style == STYLE_EU) ? PH_RY : PH_GREEN;
      PH_RY:    phase_adv = (cfg.style == STYLE_EU) ? PH_GREEN : PH_RED;
      PH_GREEN: phase_adv = PH_YELLOW;
      default:  phase_adv = PH_RED;
    endcase
  end

  // State update for one word
  always_comb begin
    phase_nxt   = phase_r;
    cycling_nxt = cycling_r;
    ticks_nxt   = ticks_r;
    if (take) begin
      if (item.mode == MODE_TICK) begin
        ticks_nxt = ticks_inc;
        if (cycling_r && expired) begin
          phase_nxt = phase_adv;
          ticks_nxt = '0;
        end
      end else begin
        case (item.command) inside
          CMD_START: begin
            cycling_nxt = 1'b1;
            phase_nxt   = PH_RED;
            ticks_nxt   = '0;
          end
          CMD_STOP, CMD_ALL_OFF: begin
            cycling_nxt = 1'b0;
            phase_nxt   = PH_OFF;
            ticks_nxt   = '0;
          end
          CMD_RED: begin
            cycling_nxt = 1'b0;
            phase_nxt   = PH_RED;
            ticks_nxt   = '0;
          end
          CMD_YELLOW: begin
            cycling_nxt = 1'b0;
            phase_nxt   = PH_YELLOW;
            ticks_nxt   = '0;
          end
          CMD_GREEN: begin
            cycling_nxt = 1'b0;
            phase_nxt   = PH_GREEN;
            ticks_nxt   = '0;
          end
          CMD_RY: begin
            cycling_nxt = 1'b0;
            phase_nxt   = PH_RY;
            ticks_nxt   = '0;
          end
          // undefined command: state holds
          default: ;
        endcase
      end
    end
  end

  assign ticks_nxt_ext = CMP_W'(ticks_nxt);

  // Result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RED;
      cycling_r   <= 1'b1;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cycling_r   <= cycling_nxt;
      ticks_r     <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload reports the state after the update
  always_ff @(posedge clk) begin
    if (take) begin
      result_r.red_lamp      <= (phase_nxt == PH_RED) || (phase_nxt == PH_RY);
      result_r.yellow_lamp   <= (phase_nxt == PH_YELLOW) || (phase_nxt == PH_RY);
      result_r.green_lamp    <= (phase_nxt == PH_GREEN);
      result_r.light_phase   <= phase_code(phase_nxt);
      result_r.cycling       <= cycling_nxt;
      result_r.time_in_phase <= ticks_nxt_ext[TIME_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

  // Start command restarts cycling at red with a cleared count
  `TLS_ASSERT(a_start_red,
    (take && item.mode == MODE_CMD && item.command == CMD_START)
      |=> (cycling_r && phase_r == PH_RED && ticks_r == '0),
    "start command did not restart cycling at red")

  // Ticks never move the phase while cycling is stopped
  `TLS_ASSERT(a_hold_stopped,
    (take && item.mode == MODE_TICK && !cycling_r) |=> $stable(phase_r),
    "phase changed on a tick while stopped")

  // A saturated counter stays saturated on ticks that do not advance
  `TLS_ASSERT(a_tick_saturate,
    (take && item.mode == MODE_TICK && ticks_r == TICK_MAX && !expired)
      |=> (ticks_r == TICK_MAX),
    "tick counter wrapped")

  // Result register is filled only by a word taken from the input stage
  `TLS_ASSERT(a_valid_source,
    $rose(out_valid_r) |-> $past(take),
    "result valid without a taken word")

endmodule

@@ src/traffic_light_sequencer.sv @@
// Traffic light sequencer.
// Input channel in_*: one word per tick or command. in_tuser carries the
// mode (0 one-millisecond tick, 1 command); in_tdata carries the command.
// Each accepted word yields exactly one result word on out_* with the lamp
// drives, phase code, cycling flag and ticks spent in the phase, all taken
// after the word has been applied.
// Config port cfg_*: cfg_we writes cfg_wdata into register cfg_addr
// (0 red, 1 yellow, 2 green, 3 red+yellow durations, 4 style); write only
// while no word is in flight.
// The input register holds an accepted word; the state update, a single step,
// writes its result into the result register. These two registers form a
// two-deep pipe that sustains one word per cycle while out_tready is high.
// Reset (rst_n low, synchronous): phase red, cycling on, count zero,
// durations 30000/3000/25000/2000 ticks, American style, no word held.
// When out_tready is low the result word holds; if the input register is
// empty it still takes one more word, and then in_tready drops.
module traffic_light_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tls_pkg::IN_DATA_W-1:0]  in_tdata,   // [2:0] command, rest zero
  input  logic                           in_tuser,   // [0] mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] red_lamp, [1] yellow_lamp, [2] green_lamp, [5:3] light_phase,
  // [6] cycling, [30:7] time_in_phase, [31] zero
  output logic [tls_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [tls_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tls_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tls_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_vld;
  logic    take;
  result_t result;

  tls_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tls_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (take),
    .item_vld  (item_vld),
    .item      (item)
  );

  tls_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_vld  (item_vld),
    .item      (item),
    .take      (take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (result)
  );

  // Pack result word, last field lowest, top bit zero
  assign out_tdata = {1'b0, result};

endmodule
